FILE: rtl/tbgr_pkg.sv
package tbgr_pkg;

   // Configuration register map (index = byte address / 4)
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int CFG_BITS      = 24;

   typedef enum logic [2:0] {
      REG_DOUBLE_CLICK_WINDOW = 3'd0,
      REG_LONG_PRESS_TIME     = 3'd1,
      REG_ACCESS_POINT_HOLD   = 3'd2,
      REG_RESET_WARNING_HOLD  = 3'd3,
      REG_FACTORY_RESET_HOLD  = 3'd4
   } reg_index_type;

   localparam logic [CFG_BITS-1:0] RST_DOUBLE_CLICK_WINDOW = 24'd500;
   localparam logic [CFG_BITS-1:0] RST_LONG_PRESS_TIME     = 24'd1000;
   localparam logic [CFG_BITS-1:0] RST_ACCESS_POINT_HOLD   = 24'd5000;
   localparam logic [CFG_BITS-1:0] RST_RESET_WARNING_HOLD  = 24'd10000;
   localparam logic [CFG_BITS-1:0] RST_FACTORY_RESET_HOLD  = 24'd15000;

   typedef struct packed {
      logic [CFG_BITS-1:0] double_click_window;
      logic [CFG_BITS-1:0] long_press_time;
      logic [CFG_BITS-1:0] access_point_hold;
      logic [CFG_BITS-1:0] reset_warning_hold;
      logic [CFG_BITS-1:0] factory_reset_hold;
   } cfg_type;

   typedef enum logic [3:0] {
      EV_SINGLE       = 4'd0,
      EV_DOUBLE_SET   = 4'd1,
      EV_DOUBLE_RESET = 4'd2,
      EV_LONG         = 4'd3,
      EV_LONG_RELEASE = 4'd4,
      EV_ACCESS_POINT = 4'd5,
      EV_IMMINENT     = 4'd6,
      EV_FACTORY      = 4'd7,
      EV_CANCEL       = 4'd8
   } event_code_type;

   // Two-button gesture stage
   typedef enum logic [5:0] {
      ST_IDLE         = 6'b000001,
      ST_OTHER_REL    = 6'b000010,
      ST_NO_FUNCTION  = 6'b000100,
      ST_ACCESS_POINT = 6'b001000,
      ST_IMMINENT     = 6'b010000,
      ST_FACTORY      = 6'b100000
   } stage_type;

   // Event slots of one transaction, in delivery order
   localparam int NUM_SLOTS   = 6;
   localparam int SLOT_EDGE   = 0;
   localparam int SLOT_LONG0  = 1;
   localparam int SLOT_LONG1  = 2;
   localparam int SLOT_HOLD   = 3;
   localparam int SLOT_CLICK0 = 4;
   localparam int SLOT_CLICK1 = 5;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      event_code_type       edge_code;
      logic                 edge_button;
      event_code_type       hold_code;
   } batch_type;

endpackage

FILE: rtl/tbgr_csr.sv
module tbgr_csr import tbgr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type        cfg_ff;
   cfg_type        cfg_in;
   logic           wr_en;
   reg_index_type  idx;
   logic [CFG_BITS-1:0] wdata;
   logic [CFG_BITS-1:0] rdata;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign wdata      = csr_pwdata[CFG_BITS-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_DOUBLE_CLICK_WINDOW: cfg_in.double_click_window = wdata;
            REG_LONG_PRESS_TIME:     cfg_in.long_press_time     = wdata;
            REG_ACCESS_POINT_HOLD:   cfg_in.access_point_hold   = wdata;
            REG_RESET_WARNING_HOLD:  cfg_in.reset_warning_hold  = wdata;
            REG_FACTORY_RESET_HOLD:  cfg_in.factory_reset_hold  = wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.double_click_window <= RST_DOUBLE_CLICK_WINDOW;
         cfg_ff.long_press_time     <= RST_LONG_PRESS_TIME;
         cfg_ff.access_point_hold   <= RST_ACCESS_POINT_HOLD;
         cfg_ff.reset_warning_hold  <= RST_RESET_WARNING_HOLD;
         cfg_ff.factory_reset_hold  <= RST_FACTORY_RESET_HOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_DOUBLE_CLICK_WINDOW: rdata = cfg_ff.double_click_window;
         REG_LONG_PRESS_TIME:     rdata = cfg_ff.long_press_time;
         REG_ACCESS_POINT_HOLD:   rdata = cfg_ff.access_point_hold;
         REG_RESET_WARNING_HOLD:  rdata = cfg_ff.reset_warning_hold;
         REG_FACTORY_RESET_HOLD:  rdata = cfg_ff.factory_reset_hold;
         default:                 rdata = '0;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_BITS-CFG_BITS){1'b0}}, rdata};
   assign cfg        = cfg_ff;

endmodule

FILE: rtl/tbgr_core.sv
module tbgr_core import tbgr_pkg::*; #(
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic        req_button,
   input  logic        req_level,
   input  logic [31:0] req_now,
   input  logic        req_motor_moving,
   input  logic        req_at_top,
   input  cfg_type     cfg,
   input  logic        batch_free,
   output logic        batch_load,
   output batch_type   batch
);

   localparam int EXT_BITS = TIME_BITS + 32;

   // strictly greater: elapsed vs. 24-bit threshold
   function automatic logic later(input logic [TIME_BITS-1:0] e,
                                  input logic [CFG_BITS-1:0]  c);
      return {{CFG_BITS{1'b0}}, e} > {{TIME_BITS{1'b0}}, c};
   endfunction

   // input register
   logic                 in_valid_ff;
   logic                 in_type_ff;
   logic                 in_button_ff;
   logic                 in_level_ff;
   logic [TIME_BITS-1:0] in_now_ff;
   logic                 in_moving_ff;
   logic                 in_top_ff;
   logic [EXT_BITS-1:0]  now_ext;

   // gesture state
   logic [1:0]           level_ff,   level_in;
   logic [1:0]           pressp_ff,  pressp_in;
   logic [1:0]           clickp_ff,  clickp_in;
   logic [TIME_BITS-1:0] press_ff [2];
   logic [TIME_BITS-1:0] press_in [2];
   logic [TIME_BITS-1:0] click_ff [2];
   logic [TIME_BITS-1:0] click_in [2];
   stage_type            stage_ff,   stage_in;

   logic                 b;
   logic [TIME_BITS-1:0] e_click_old;
   logic [TIME_BITS-1:0] e_press [2];
   logic [TIME_BITS-1:0] e_click [2];

   assign now_ext    = {{TIME_BITS{1'b0}}, req_now};
   assign batch_load = in_valid_ff & batch_free;
   assign req_ready  = ~in_valid_ff | batch_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_type_ff   <= req_type;
         in_button_ff <= req_button;
         in_level_ff  <= req_level;
         in_now_ff    <= now_ext[TIME_BITS-1:0];
         in_moving_ff <= req_motor_moving;
         in_top_ff    <= req_at_top;
      end
   end

   assign b           = in_button_ff;
   assign e_click_old = in_now_ff - click_ff[b];

   // One pass: edge, long press, two-button hold, pending click
   always_comb begin
      level_in  = level_ff;
      pressp_in = pressp_ff;
      clickp_in = clickp_ff;
      press_in  = press_ff;
      click_in  = click_ff;
      stage_in  = stage_ff;
      batch     = '0;
      batch.edge_code = EV_SINGLE;
      batch.hold_code = EV_SINGLE;

      // edge
      if (in_type_ff && (in_level_ff != level_ff[b])) begin
         if (in_level_ff) begin
            press_in[b]  = in_now_ff;
            pressp_in[b] = 1'b1;
         end else begin
            if (stage_ff == ST_IDLE) begin
               if (!pressp_ff[b]) begin
                  batch.mask[SLOT_EDGE] = 1'b1;
                  batch.edge_code       = EV_LONG_RELEASE;
                  batch.edge_button     = b;
               end else if (clickp_ff[b] &&
                            ({{CFG_BITS{1'b0}}, e_click_old} <
                             {{TIME_BITS{1'b0}}, cfg.double_click_window})) begin
                  batch.mask[SLOT_EDGE] = 1'b1;
                  batch.edge_code       = in_top_ff ? EV_DOUBLE_RESET : EV_DOUBLE_SET;
                  batch.edge_button     = b;
                  clickp_in[b]          = 1'b0;
               end else begin
                  click_in[b]  = in_now_ff;
                  clickp_in[b] = 1'b1;
               end
            end else begin
               if (stage_ff == ST_IMMINENT) begin
                  batch.mask[SLOT_EDGE] = 1'b1;
                  batch.edge_code       = EV_CANCEL;
                  batch.edge_button     = 1'b0;
               end
               stage_in = ST_OTHER_REL;
            end
            pressp_in[b] = 1'b0;
         end
         level_in[b] = in_level_ff;
      end

      e_press[0] = in_now_ff - press_in[0];
      e_press[1] = in_now_ff - press_in[1];

      // long press, only while no two-button gesture runs
      if (stage_in == ST_IDLE) begin
         if (pressp_in[0] && later(e_press[0], cfg.long_press_time)) begin
            batch.mask[SLOT_LONG0] = 1'b1;
            pressp_in[0]           = 1'b0;
         end
         if (pressp_in[1] && later(e_press[1], cfg.long_press_time)) begin
            batch.mask[SLOT_LONG1] = 1'b1;
            pressp_in[1]           = 1'b0;
         end
      end

      // two-button holds: factory reset checked first, then reset warning, then access point
      if (level_in[0] && level_in[1]) begin
         if (later(e_press[0], cfg.factory_reset_hold) &&
             later(e_press[1], cfg.factory_reset_hold)) begin
            if (stage_in != ST_FACTORY) begin
               batch.mask[SLOT_HOLD] = 1'b1;
               batch.hold_code       = EV_FACTORY;
               stage_in              = ST_FACTORY;
            end
         end else if (later(e_press[0], cfg.reset_warning_hold) &&
                      later(e_press[1], cfg.reset_warning_hold)) begin
            if (stage_in != ST_IMMINENT) begin
               batch.mask[SLOT_HOLD] = 1'b1;
               batch.hold_code       = EV_IMMINENT;
               stage_in              = ST_IMMINENT;
            end
         end else if (later(e_press[0], cfg.access_point_hold) &&
                      later(e_press[1], cfg.access_point_hold)) begin
            if (stage_in != ST_ACCESS_POINT) begin
               batch.mask[SLOT_HOLD] = 1'b1;
               batch.hold_code       = EV_ACCESS_POINT;
               stage_in              = ST_ACCESS_POINT;
            end
         end else begin
            stage_in = ST_NO_FUNCTION;
         end
      end
      if (!level_in[0] && !level_in[1]) begin
         stage_in = ST_IDLE;
      end

      // pending single clicks
      e_click[0] = in_now_ff - click_in[0];
      e_click[1] = in_now_ff - click_in[1];
      if (clickp_in[0] &&
          (in_moving_ff || later(e_click[0], cfg.double_click_window))) begin
         batch.mask[SLOT_CLICK0] = 1'b1;
         clickp_in[0]            = 1'b0;
      end
      if (clickp_in[1] &&
          (in_moving_ff || later(e_click[1], cfg.double_click_window))) begin
         batch.mask[SLOT_CLICK1] = 1'b1;
         clickp_in[1]            = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         pressp_ff <= '0;
         clickp_ff <= '0;
         press_ff  <= '{default: '0};
         click_ff  <= '{default: '0};
         stage_ff  <= ST_NO_FUNCTION;
      end else if (batch_load) begin
         level_ff  <= level_in;
         pressp_ff <= pressp_in;
         clickp_ff <= clickp_in;
         press_ff  <= press_in;
         click_ff  <= click_in;
         stage_ff  <= stage_in;
      end
   end

endmodule

FILE: rtl/tbgr_evq.sv
module tbgr_evq import tbgr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       batch_load,
   input  batch_type  batch,
   output logic       batch_free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_event_code,
   output logic       rsp_event_button,
   output logic       rsp_last
);

   logic [NUM_SLOTS-1:0] mask_ff;
   logic [NUM_SLOTS-1:0] mask_in;
   logic [NUM_SLOTS-1:0] sel;
   logic [NUM_SLOTS-1:0] rest;
   event_code_type       edge_code_ff;
   logic                 edge_button_ff;
   event_code_type       hold_code_ff;

   assign sel        = mask_ff & (~mask_ff + 1'b1);
   assign rest       = mask_ff & ~sel;
   assign rsp_valid  = |mask_ff;
   assign rsp_last   = ~|rest;
   assign batch_free = ~rsp_valid | (rsp_ready & rsp_last);

   always_comb begin
      mask_in = mask_ff;
      if (batch_load) begin
         mask_in = batch.mask;
      end else if (rsp_valid && rsp_ready) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (batch_load) begin
         edge_code_ff   <= batch.edge_code;
         edge_button_ff <= batch.edge_button;
         hold_code_ff   <= batch.hold_code;
      end
   end

   always_comb begin
      rsp_event_code   = EV_SINGLE;
      rsp_event_button = 1'b0;
      if (sel[SLOT_EDGE]) begin
         rsp_event_code   = edge_code_ff;
         rsp_event_button = edge_button_ff;
      end else if (sel[SLOT_LONG0]) begin
         rsp_event_code   = EV_LONG;
      end else if (sel[SLOT_LONG1]) begin
         rsp_event_code   = EV_LONG;
         rsp_event_button = 1'b1;
      end else if (sel[SLOT_HOLD]) begin
         rsp_event_code   = hold_code_ff;
      end else if (sel[SLOT_CLICK1]) begin
         rsp_event_button = 1'b1;
      end
   end

endmodule

FILE: rtl/two_button_gesture_recognizer.sv
// Two-button gesture recognizer. Each req transaction carries a time stamp, the
// motor-moving and at-top flags and either a button level change or a plain
// tick; the block turns these into gesture events (single click, double click
// set/reset limit, long press and its release, access point start, factory
// reset imminent / reset / cancel), oldest first, one rsp transaction each,
// with rsp_last marking the final event of a request. A request that raises
// no event produces no response. Timing: a request waits in the input
// register, where the whole step is evaluated, until the event register is
// free; then its events are moved into the output event register and leave
// one per cycle while rsp_ready is high. A request is therefore accepted
// every cycle as long as each raises at most one event and rsp_ready stays
// high; a request with several events holds the next one in the input
// register until its last event is taken. The next request is taken while
// events still drain. Thresholds live in five 24-bit APB registers at byte
// offsets 0x00..0x10; write them only while the block is idle. Elapsed times
// wrap modulo 2^TIME_BITS.
module two_button_gesture_recognizer import tbgr_pkg::*; #(
   parameter int TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_type,
   input  logic                     req_button,
   input  logic                     req_level,
   input  logic [31:0]              req_now,
   input  logic                     req_motor_moving,
   input  logic                     req_at_top,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [3:0]               rsp_event_code,
   output logic                     rsp_event_button,
   output logic                     rsp_last,
   // configuration
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type   cfg;
   batch_type batch;
   logic      batch_load;
   logic      batch_free;

   // threshold registers
   tbgr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register, button state and the single-pass gesture step
   tbgr_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_button       (req_button),
      .req_level        (req_level),
      .req_now          (req_now),
      .req_motor_moving (req_motor_moving),
      .req_at_top       (req_at_top),
      .cfg              (cfg),
      .batch_free       (batch_free),
      .batch_load       (batch_load),
      .batch            (batch)
   );

   // event register, drains one event per response transaction
   tbgr_evq u_evq (
      .clock            (clock),
      .reset            (reset),
      .batch_load       (batch_load),
      .batch            (batch),
      .batch_free       (batch_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_code   (rsp_event_code),
      .rsp_event_button (rsp_event_button),
      .rsp_last         (rsp_last)
   );

endmodule
